[sv/lsag_pkg.sv]
// Shared types, codes and helper functions for the light sensor auto-gain block.
package lsag_pkg;

  localparam logic [2:0] IT_TOP  = 3'd4;
  localparam logic [2:0] TOP_EXP = 3'd7;

  // Configuration register indexes
  localparam logic [2:0] CFG_ENABLE   = 3'd0;
  localparam logic [2:0] CFG_LOW      = 3'd1;
  localparam logic [2:0] CFG_HIGH     = 3'd2;
  localparam logic [2:0] CFG_LUX      = 3'd3;
  localparam logic [2:0] CFG_INIT_IT  = 3'd4;
  localparam logic [2:0] CFG_INIT_GN  = 3'd5;
  localparam logic [2:0] CFG_INIT_DD  = 3'd6;

  localparam logic [1:0] GAIN_1X = 2'd0;
  localparam logic [1:0] GAIN_2X = 2'd1;
  localparam logic [1:0] GAIN_4X = 2'd2;

  typedef enum logic [2:0] {
    ACT_START   = 3'd0,
    ACT_RECONF  = 3'd1,
    ACT_PUBLISH = 3'd2,
    ACT_INVALID = 3'd3,
    ACT_SKIP    = 3'd4
  } action_e;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DECIDE = 6'b000010,
    ST_SEARCH = 6'b000100,
    ST_CHECK  = 6'b001000,
    ST_LUX    = 6'b010000,
    ST_FINISH = 6'b100000
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic    cap_in;
    logic    prep;
    logic    start_rd;
    logic    fail;
    logic    good;
    logic    k_zero;
    logic    k_top;
    logic    k_inc;
    logic    apply;
    logic    publish;
    logic    set_act;
    action_e act;
    logic    load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_tick;
    logic busy;
    logic ok;
    logic adjust;
    logic clipped;
    logic zero;
    logic more;
    logic k_eq_e;
    logic out_free;
  } sts_t;

  function automatic logic [1:0] gain_exp(input logic [1:0] code);
    logic [1:0] r;
    case (code)
      GAIN_2X: r = 2'd1;
      GAIN_4X: r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  // Integration time in ms: 50 * 2^it, held at 800 for it of 4 and above
  function automatic logic [11:0] it_ms(input logic [2:0] it);
    logic [11:0] r;
    case (it)
      3'd0:    r = 12'd50;
      3'd1:    r = 12'd100;
      3'd2:    r = 12'd200;
      3'd3:    r = 12'd400;
      default: r = 12'd800;
    endcase
    return r;
  endfunction

endpackage

[sv/lsag_ctrl.sv]
// Sequencing state machine of the auto-gain block.
module lsag_ctrl import lsag_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    cmd_o.act = ACT_START;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap_in = 1'b1;
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd_o.prep = 1'b1;
        if (sts_i.is_tick) begin
          cmd_o.set_act = 1'b1;
          if (sts_i.busy) begin
            cmd_o.act = ACT_SKIP;
          end else begin
            cmd_o.start_rd = 1'b1;
            cmd_o.act = ACT_START;
          end
          state_d = ST_FINISH;
        end else if (!sts_i.busy) begin
          // stray completion, no result
          state_d = ST_IDLE;
        end else if (!sts_i.ok) begin
          cmd_o.fail = 1'b1;
          cmd_o.set_act = 1'b1;
          cmd_o.act = ACT_INVALID;
          state_d = ST_FINISH;
        end else begin
          cmd_o.good = 1'b1;
          if (sts_i.adjust) begin
            if (sts_i.clipped) begin
              cmd_o.k_zero = 1'b1;
              state_d = ST_CHECK;
            end else if (sts_i.zero) begin
              cmd_o.k_top = 1'b1;
              state_d = ST_CHECK;
            end else begin
              cmd_o.k_zero = 1'b1;
              state_d = ST_SEARCH;
            end
          end else begin
            state_d = ST_LUX;
          end
        end
      end
      ST_SEARCH: begin
        if (sts_i.more) begin
          cmd_o.k_inc = 1'b1;
        end else begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.k_eq_e) begin
          state_d = ST_LUX;
        end else begin
          cmd_o.apply = 1'b1;
          cmd_o.set_act = 1'b1;
          cmd_o.act = ACT_RECONF;
          state_d = ST_FINISH;
        end
      end
      ST_LUX: begin
        cmd_o.publish = 1'b1;
        cmd_o.set_act = 1'b1;
        cmd_o.act = ACT_PUBLISH;
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> sts_i.out_free)
    else $error("result loaded while output register is occupied");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH && !sts_i.more) |=> state_q == ST_CHECK)
    else $error("search did not end in the check step");

endmodule

[sv/lsag_dp.sv]
// Datapath: configuration, live gain settings, window search, lux product and result register.
module lsag_dp import lsag_pkg::*; #(
  parameter int unsigned MAX_RETRIES = 2,
  parameter int unsigned CLIP_LEVEL  = 64224
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  input  logic        kind_i,
  input  logic [15:0] ambient_counts_i,
  input  logic        read_ok_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  action_o,
  output logic [2:0]  integ_exp_out_o,
  output logic [1:0]  gain_code_out_o,
  output logic        digital_double_out_o,
  output logic [11:0] wait_ms_o,
  output logic [46:0] lux_fixed_o,
  output logic        warning_o
);

  // configuration
  logic        en_q;
  logic [15:0] low_q, high_q;
  logic [23:0] lpc_q;
  // live state
  logic [2:0]  it_q;
  logic [1:0]  gain_q;
  logic        dd_q;
  logic [1:0]  retries_q;
  logic        busy_q, warn_q;
  // request capture and working values
  logic        kind_q, ok_q;
  logic [15:0] counts_q;
  logic [39:0] prod_q;
  logic [23:0] num_q;
  logic [2:0]  k_q;
  action_e     act_q;
  logic [11:0] wait_q;
  logic [46:0] lux_q;
  // result register
  logic        out_valid_q;
  action_e     out_act_q;
  logic [2:0]  out_it_q;
  logic [1:0]  out_gain_q;
  logic        out_dd_q;
  logic [11:0] out_wait_q;
  logic [46:0] out_lux_q;
  logic        out_warn_q;

  logic [2:0]  sens_e;
  logic        clipped, outside;
  logic [16:0] win_sum;
  logic [23:0] num_d;
  logic [24:0] cnt_shift;
  logic [2:0]  new_it;
  logic [1:0]  rem;
  logic [1:0]  new_gain;
  logic        new_dd;
  logic [11:0] wait_d;
  logic [46:0] lux_d;
  logic [2:0]  cfg_it;
  logic [1:0]  cfg_gain;

  assign sens_e  = it_q + 3'(gain_exp(gain_q)) + 3'(dd_q);
  assign clipped = counts_q >= 16'(CLIP_LEVEL);
  assign outside = clipped || (counts_q < low_q) || (counts_q > high_q);
  assign win_sum = {1'b0, low_q} + {1'b0, high_q};
  assign num_d   = {7'd0, win_sum} << sens_e;
  // counts * 2^(k+2), compared against (low+high) * 2^e
  assign cnt_shift = {9'd0, counts_q} << (4'(k_q) + 4'd2);

  // split k: integration first, then analog gain, then digital doubling
  assign new_it   = (k_q > IT_TOP) ? IT_TOP : k_q;
  assign rem      = 2'(k_q - new_it);
  assign new_gain = (rem >= 2'd2) ? GAIN_4X : rem;
  assign new_dd   = (rem == 2'd3);
  assign wait_d   = it_ms(it_q) + (it_ms(new_it) << 1);
  assign lux_d    = {7'd0, prod_q} << (TOP_EXP - sens_e);

  assign cfg_it   = (cfg_data_i[2:0] > IT_TOP) ? IT_TOP : cfg_data_i[2:0];
  assign cfg_gain = (cfg_data_i[1:0] == 2'd3) ? GAIN_1X : cfg_data_i[1:0];

  always_comb begin
    sts_o.is_tick  = !kind_q;
    sts_o.busy     = busy_q;
    sts_o.ok       = ok_q;
    sts_o.adjust   = en_q && (retries_q != 2'd0) && outside;
    sts_o.clipped  = clipped;
    sts_o.zero     = (counts_q == 16'd0);
    sts_o.more     = (k_q != TOP_EXP) && (cnt_shift <= {1'b0, num_q});
    sts_o.k_eq_e   = (k_q == sens_e);
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q        <= 1'b1;
      low_q       <= 16'd6553;
      high_q      <= 16'd52428;
      lpc_q       <= 24'd0;
      it_q        <= 3'd0;
      gain_q      <= GAIN_1X;
      dd_q        <= 1'b0;
      retries_q   <= 2'd0;
      busy_q      <= 1'b0;
      warn_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_ENABLE:  en_q   <= cfg_data_i[0];
          CFG_LOW:     low_q  <= cfg_data_i[15:0];
          CFG_HIGH:    high_q <= cfg_data_i[15:0];
          CFG_LUX:     lpc_q  <= cfg_data_i;
          CFG_INIT_IT: it_q   <= cfg_it;
          CFG_INIT_GN: gain_q <= cfg_gain;
          CFG_INIT_DD: dd_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (cmd_i.start_rd) begin
        busy_q    <= 1'b1;
        retries_q <= 2'(MAX_RETRIES);
      end
      if (cmd_i.fail) begin
        warn_q <= 1'b1;
        busy_q <= 1'b0;
      end
      if (cmd_i.good) begin
        warn_q <= 1'b0;
      end
      if (cmd_i.apply) begin
        it_q      <= new_it;
        gain_q    <= new_gain;
        dd_q      <= new_dd;
        retries_q <= retries_q - 2'd1;
      end
      if (cmd_i.publish) begin
        busy_q <= 1'b0;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      kind_q   <= kind_i;
      counts_q <= ambient_counts_i;
      ok_q     <= read_ok_i;
    end
    if (cmd_i.prep) begin
      prod_q <= 40'(counts_q) * 40'(lpc_q);
      num_q  <= num_d;
      wait_q <= 12'd0;
      lux_q  <= 47'd0;
    end
    if (cmd_i.k_zero) begin
      k_q <= 3'd0;
    end else if (cmd_i.k_top) begin
      k_q <= TOP_EXP;
    end else if (cmd_i.k_inc) begin
      k_q <= k_q + 3'd1;
    end
    if (cmd_i.set_act) begin
      act_q <= cmd_i.act;
    end
    if (cmd_i.apply) begin
      wait_q <= wait_d;
    end
    if (cmd_i.publish) begin
      lux_q <= lux_d;
    end
    if (cmd_i.load_out) begin
      out_act_q  <= act_q;
      out_it_q   <= it_q;
      out_gain_q <= gain_q;
      out_dd_q   <= dd_q;
      out_wait_q <= wait_q;
      out_lux_q  <= lux_q;
      out_warn_q <= warn_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign action_o             = out_act_q;
  assign integ_exp_out_o      = out_it_q;
  assign gain_code_out_o      = out_gain_q;
  assign digital_double_out_o = out_dd_q;
  assign wait_ms_o            = out_wait_q;
  assign lux_fixed_o          = out_lux_q;
  assign warning_o            = out_warn_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.apply |=> retries_q == $past(retries_q) - 2'd1)
    else $error("reconfigure did not use up one retry");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.publish |=> !busy_q)
    else $error("busy still set after publishing lux");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_act_q != ACT_RECONF) |-> out_wait_q == 12'd0)
    else $error("nonzero wait on a result that is not a reconfigure");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_act_q != ACT_PUBLISH) |-> out_lux_q == 47'd0)
    else $error("nonzero lux on a result that is not a publish");

endmodule

[sv/light_sensor_auto_gain.sv]
// Light sensor auto-gain top level: handshake ports, controller and datapath.
// Each request (update tick or completed reading) is taken when the block is
// idle and yields at most one result. A tick or a failed read passes through
// the decide and finish steps and a stray completion goes from decide back to
// idle; a reading inside the window, or one that may not change sensitivity,
// goes through the lux step; a clipped or zero reading goes through the check
// step, and the lux step too when it keeps the sensitivity; any other reading
// outside the window first runs the window search, which tests one doubling of
// the target per cycle. A finished result sits in an output register, so the
// block goes back to idle while it waits to be taken; only a second result
// waiting on a full output register holds the block up. Configuration writes
// are taken in any cycle and must come only while idle.
module light_sensor_auto_gain import lsag_pkg::*; #(
  parameter int unsigned MAX_RETRIES = 2,
  parameter int unsigned CLIP_LEVEL  = 64224
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [15:0] ambient_counts_i,
  input  logic        read_ok_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  action_o,
  output logic [2:0]  integ_exp_out_o,
  output logic [1:0]  gain_code_out_o,
  output logic        digital_double_out_o,
  output logic [11:0] wait_ms_o,
  output logic [46:0] lux_fixed_o,
  output logic        warning_o
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  lsag_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lsag_dp #(
    .MAX_RETRIES (MAX_RETRIES),
    .CLIP_LEVEL  (CLIP_LEVEL)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .kind_i               (kind_i),
    .ambient_counts_i     (ambient_counts_i),
    .read_ok_i            (read_ok_i),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .action_o             (action_o),
    .integ_exp_out_o      (integ_exp_out_o),
    .gain_code_out_o      (gain_code_out_o),
    .digital_double_out_o (digital_double_out_o),
    .wait_ms_o            (wait_ms_o),
    .lux_fixed_o          (lux_fixed_o),
    .warning_o            (warning_o)
  );

endmodule
